/* design/disparity_to_depth_unit_assert.svh */
// Assertion macros for the disparity-to-depth top level.
`ifndef DISPARITY_TO_DEPTH_UNIT_ASSERT_SVH
`define DISPARITY_TO_DEPTH_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* design/d2d_pkg.sv */
// Shared constants and types of the disparity-to-depth unit.
package d2d_pkg;

    localparam int DispW    = 16;
    localparam int FbW      = 32;
    localparam int DepthW   = 32;
    localparam int QuoW     = FbW + 4;
    localparam int NumSteps = QuoW;
    localparam int MulW     = FbW + 10;
    localparam int MmShift  = 12;
    localparam int CfgIdxW  = 2;

    localparam logic [9:0]        MmPerMetre = 10'd1000;
    localparam logic [DepthW-1:0] MmMax      = 32'h0000_FFFF;

    localparam logic [CfgIdxW-1:0] CfgFocalBaseline = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgOutputMode    = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgInvalidDepth  = 2'd2;

    localparam logic ModeMm = 1'b0;
    localparam logic ModeQ  = 1'b1;

    // Payload carried by each divider cell.
    typedef struct packed {
        logic [DispW-1:0] rem;
        logic [QuoW-1:0]  word;
        logic [DispW-1:0] divisor;
        logic             invalid;
    } t_div_word;

endpackage

/* design/d2d_div_cell.sv */
// One restoring-division step: resolves one quotient bit and registers the result.
module d2d_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  d2d_pkg::t_div_word  i_word,
    output logic                o_valid,
    output d2d_pkg::t_div_word  o_word
);

    logic               r_valid;
    d2d_pkg::t_div_word r_word;
    d2d_pkg::t_div_word n_word;
    logic [d2d_pkg::DispW:0]   s_partial;
    logic [d2d_pkg::DispW+1:0] s_diff;
    logic                      s_ge;

    // The numerator bits leave at the top of the word while quotient bits enter at the bottom.
    always_comb begin
        s_partial = {i_word.rem, i_word.word[d2d_pkg::QuoW-1]};
        s_diff    = {1'b0, s_partial} - {2'b00, i_word.divisor};
        s_ge      = !s_diff[d2d_pkg::DispW+1];
        n_word         = i_word;
        n_word.word    = {i_word.word[d2d_pkg::QuoW-2:0], s_ge};
        n_word.rem     = s_ge ? s_diff[d2d_pkg::DispW-1:0] : s_partial[d2d_pkg::DispW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

/* design/disparity_to_depth_unit.sv */
// Top level of the disparity-to-depth unit: registers, numerator stage, divider chain, output.
//
// Converts a stream of disparities (sixteenths of a pixel) into depths.
// Input beats arrive on i_in_valid / o_in_ready with i_disparity_raw; result
// beats leave on o_out_valid / i_out_ready with o_depth_value, o_is_invalid
// and o_saturated. Every input beat gives exactly one result beat, in order.
// The configuration port writes focal_baseline, output_mode and
// invalid_depth by index; it should be written only while no beat is in flight.
// A result passes through a front register that forms the numerator,
// a chain of 36 division cells that resolve one quotient bit each, and
// the output register, which takes the saturated depth. The chain takes a
// new beat every cycle while the output is not stalled, so the throughput is one beat per clock.
// When the receiver stalls with a result waiting, the whole chain holds and
// o_in_ready falls; it rises again in the cycle the result is taken.
// Synchronous reset empties the chain and clears all configuration to zero.
module disparity_to_depth_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [d2d_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [d2d_pkg::FbW-1:0]        i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [d2d_pkg::DispW-1:0]      i_disparity_raw,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [d2d_pkg::DepthW-1:0]     o_depth_value,
    output logic                           o_is_invalid,
    output logic                           o_saturated
);

`include "disparity_to_depth_unit_assert.svh"

    logic [d2d_pkg::FbW-1:0]    r_fb;
    logic                       r_mode;
    logic [d2d_pkg::DepthW-1:0] r_inv_depth;

    logic                       s_en;
    logic [d2d_pkg::MulW-1:0]   s_mul;
    d2d_pkg::t_div_word         n_front;

    logic                       s_valid [0:d2d_pkg::NumSteps];
    d2d_pkg::t_div_word         s_word  [0:d2d_pkg::NumSteps];
    logic                       r_front_valid;
    d2d_pkg::t_div_word         r_front;

    logic                       r_out_valid;
    logic [d2d_pkg::DepthW-1:0] r_out_depth;
    logic                       r_out_invalid;
    logic                       r_out_sat;
    logic                       r_out_mode;
    logic [d2d_pkg::DepthW-1:0] n_out_depth;
    logic                       n_out_sat;
    logic [d2d_pkg::QuoW-1:0]   s_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb        <= '0;
            r_mode      <= d2d_pkg::ModeMm;
            r_inv_depth <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                d2d_pkg::CfgFocalBaseline: r_fb        <= i_cfg_data;
                d2d_pkg::CfgOutputMode:    r_mode      <= i_cfg_data[0];
                d2d_pkg::CfgInvalidDepth:  r_inv_depth <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The chain advances whenever the output register is empty or being emptied.
    assign s_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = s_en;

    // Millimetres: fb*1000/2^12 first, which leaves the floored quotient unchanged.
    always_comb begin
        s_mul           = r_fb * d2d_pkg::MmPerMetre;
        n_front.rem     = '0;
        n_front.divisor = i_disparity_raw;
        n_front.invalid = (i_disparity_raw == '0);
        if (r_mode == d2d_pkg::ModeMm) begin
            n_front.word = d2d_pkg::QuoW'(s_mul[d2d_pkg::MulW-1:d2d_pkg::MmShift]);
        end else begin
            n_front.word = {r_fb, 4'b0000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (s_en) begin
            r_front_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_front <= n_front;
        end
    end

    assign s_valid[0] = r_front_valid;
    assign s_word[0]  = r_front;

    for (genvar g = 0; g < d2d_pkg::NumSteps; g++) begin : g_cell
        d2d_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_en),
            .i_valid (s_valid[g]),
            .i_word  (s_word[g]),
            .o_valid (s_valid[g+1]),
            .o_word  (s_word[g+1])
        );
    end

    always_comb begin
        s_quo = s_word[d2d_pkg::NumSteps].word;
        n_out_sat = 1'b0;
        if (s_word[d2d_pkg::NumSteps].invalid) begin
            if (r_mode == d2d_pkg::ModeMm && r_inv_depth[d2d_pkg::DepthW-1:16] != '0) begin
                n_out_depth = d2d_pkg::MmMax;
            end else begin
                n_out_depth = r_inv_depth;
            end
        end else if (r_mode == d2d_pkg::ModeMm) begin
            if (s_quo[d2d_pkg::QuoW-1:16] != '0) begin
                n_out_depth = d2d_pkg::MmMax;
                n_out_sat   = 1'b1;
            end else begin
                n_out_depth = {16'h0000, s_quo[15:0]};
            end
        end else begin
            if (s_quo[d2d_pkg::QuoW-1:d2d_pkg::DepthW] != '0) begin
                n_out_depth = '1;
                n_out_sat   = 1'b1;
            end else begin
                n_out_depth = s_quo[d2d_pkg::DepthW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_en) begin
            r_out_valid <= s_valid[d2d_pkg::NumSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_out_depth   <= n_out_depth;
            r_out_invalid <= s_word[d2d_pkg::NumSteps].invalid;
            r_out_sat     <= n_out_sat;
            r_out_mode    <= r_mode;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_depth_value = r_out_depth;
    assign o_is_invalid  = r_out_invalid;
    assign o_saturated   = r_out_sat;

    `ASSERT_IMPL(a_invalid_not_sat, r_out_valid && r_out_invalid, !r_out_sat)
    `ASSERT_IMPL(a_mm_range, r_out_valid && r_out_mode == d2d_pkg::ModeMm, r_out_depth[d2d_pkg::DepthW-1:16] == '0)
    `ASSERT_IMPL(a_q_sat_max, r_out_valid && r_out_sat && r_out_mode == d2d_pkg::ModeQ, r_out_depth == '1)
    `ASSERT_NEXT(a_chain_to_out, s_valid[d2d_pkg::NumSteps] && s_en, r_out_valid)

endmodule
